/* src/velocity_slew_limiter_watchdog_top_defines.svh */
// -----------------------------------------------------------------------------
// Velocity slew limiter assertion macros
// Shared property wrappers for the port-level checker.
// -----------------------------------------------------------------------------
`ifndef VELOCITY_SLEW_LIMITER_WATCHDOG_TOP_DEFINES_SVH
`define VELOCITY_SLEW_LIMITER_WATCHDOG_TOP_DEFINES_SVH

// Same-cycle implication, gated off while the disable term is high
`define VSLW_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off while the disable term is high
`define VSLW_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/vslw_pkg.sv */
// -----------------------------------------------------------------------------
// vslw_pkg
// Types and constants shared by the velocity slew limiter modules.
// -----------------------------------------------------------------------------
`default_nettype none

package vslw_pkg;

  // Input command codes
  localparam logic CMD_VELOCITY = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // Configuration register indexes
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_LINEAR    = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ANGULAR   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACCEL_STEP    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT_TICKS = 3'd3;

  localparam int CFG_DATA_WIDTH = 16;
  localparam int LIMIT_WIDTH    = 15;
  localparam int TIMEOUT_WIDTH  = 16;
  localparam int FIELD_WIDTH    = 16;

  // Register reset values
  localparam logic [LIMIT_WIDTH-1:0]   RST_MAX_LINEAR    = 15'd4096;
  localparam logic [LIMIT_WIDTH-1:0]   RST_MAX_ANGULAR   = 15'd3217;
  localparam logic [LIMIT_WIDTH-1:0]   RST_ACCEL_STEP    = 15'd41;
  localparam logic [TIMEOUT_WIDTH-1:0] RST_TIMEOUT_TICKS = 16'd25;

  // 180/pi scaled to Q10.6 output, held as DEG_SCALE / 2^DEG_SHIFT
  localparam int DEG_SCALE_WIDTH = 24;
  localparam int DEG_SHIFT       = 24;
  localparam logic [DEG_SCALE_WIDTH-1:0] DEG_SCALE = 24'd15019745;

  // Output saturation codes
  localparam logic [FIELD_WIDTH-1:0] SAT_POS = 16'h7fff;
  localparam logic [FIELD_WIDTH-1:0] SAT_NEG = 16'h8000;

  // Throttle divider: one quotient bit per step
  localparam int DIV_STEPS     = 15;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_WATCH,
    S_SLEW,
    S_MUL,
    S_DIV,
    S_DONE
  } vslw_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic do_cmd;
    logic do_watch;
    logic do_slew;
    logic do_mul;
    logic div_step;
    logic load_out;
  } vslw_cmd_t;

endpackage

`default_nettype wire

/* src/vslw_ctrl.sv */
// -----------------------------------------------------------------------------
// vslw_ctrl
// Sequencer for command and tick items, divider step count, output valid.
// -----------------------------------------------------------------------------
`default_nettype none

module vslw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               command,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      vslw_pkg::vslw_cmd_t ctl
);

  vslw_pkg::vslw_state_t state, state_next;
  logic [vslw_pkg::DIV_CNT_WIDTH-1:0] div_cnt, div_cnt_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= vslw_pkg::S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  // Output valid: set on load, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    in_ready     = 1'b0;
    ctl          = '0;
    unique case (state)
      vslw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = (command == vslw_pkg::CMD_TICK) ? vslw_pkg::S_WATCH :
                                                            vslw_pkg::S_CMD;
        end
      end
      vslw_pkg::S_CMD: begin
        ctl.do_cmd = 1'b1;
        state_next = vslw_pkg::S_IDLE;
      end
      vslw_pkg::S_WATCH: begin
        ctl.do_watch = 1'b1;
        state_next   = vslw_pkg::S_SLEW;
      end
      vslw_pkg::S_SLEW: begin
        ctl.do_slew = 1'b1;
        state_next  = vslw_pkg::S_MUL;
      end
      vslw_pkg::S_MUL: begin
        ctl.do_mul   = 1'b1;
        div_cnt_next = '0;
        state_next   = vslw_pkg::S_DIV;
      end
      vslw_pkg::S_DIV: begin
        ctl.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == vslw_pkg::DIV_CNT_WIDTH'(vslw_pkg::DIV_STEPS - 1)) begin
          state_next = vslw_pkg::S_DONE;
        end
      end
      vslw_pkg::S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = vslw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = vslw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/vslw_datapath.sv */
// -----------------------------------------------------------------------------
// vslw_datapath
// Config registers, targets, slew, watchdog counter, angle multiply and
// restoring throttle divider with output registers.
// -----------------------------------------------------------------------------
`default_nettype none

module vslw_datapath #(
  parameter int VALUE_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire vslw_pkg::vslw_cmd_t                    ctl,
  input  wire logic                                   cfg_we,
  input  wire logic [vslw_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [vslw_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  wire logic signed [vslw_pkg::FIELD_WIDTH-1:0] linear_cmd,
  input  wire logic signed [vslw_pkg::FIELD_WIDTH-1:0] angular_cmd,
  output      logic signed [vslw_pkg::FIELD_WIDTH-1:0] throttle,
  output      logic signed [vslw_pkg::FIELD_WIDTH-1:0] steer_angle
);

  localparam int FW  = vslw_pkg::FIELD_WIDTH;
  localparam int LW  = vslw_pkg::LIMIT_WIDTH;
  localparam int EW  = (VALUE_WIDTH > FW ? VALUE_WIDTH : FW) + 2;
  localparam int TW  = (COUNT_WIDTH > vslw_pkg::TIMEOUT_WIDTH) ?
                       COUNT_WIDTH : vslw_pkg::TIMEOUT_WIDTH;
  localparam int MW  = (VALUE_WIDTH > LW) ? VALUE_WIDTH : LW;
  localparam int PW  = VALUE_WIDTH + vslw_pkg::DEG_SCALE_WIDTH;
  localparam int RW  = PW + 1 - vslw_pkg::DEG_SHIFT;
  localparam int CPW = (RW > FW + 1) ? RW : FW + 1;
  localparam logic signed [EW-1:0] VMAX_E =
    EW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic [PW:0]        ROUND_HALF = (PW + 1)'(64'd1 << (vslw_pkg::DEG_SHIFT - 1));
  localparam logic [CPW-1:0]     POS_LIMIT  = CPW'(32767);
  localparam logic [CPW-1:0]     NEG_LIMIT  = CPW'(32768);

  function automatic logic signed [EW-1:0] clamp_sym(
    input logic signed [EW-1:0] v,
    input logic signed [EW-1:0] lim
  );
    logic signed [EW-1:0] r;
    r = v;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  function automatic logic signed [EW-1:0] slew(
    input logic signed [EW-1:0] tgt,
    input logic signed [EW-1:0] cur,
    input logic signed [EW-1:0] step
  );
    logic signed [EW-1:0] diff;
    logic signed [EW-1:0] mag;
    logic signed [EW-1:0] r;
    diff = tgt - cur;
    mag  = diff[EW-1] ? -diff : diff;
    if (mag < step) begin
      r = tgt;
    end else if (diff > 0) begin
      r = cur + step;
    end else begin
      r = cur - step;
    end
    return r;
  endfunction

  // Config registers
  logic [LW-1:0]                       max_linear;
  logic [LW-1:0]                       max_angular;
  logic [LW-1:0]                       accel_step;
  logic [vslw_pkg::TIMEOUT_WIDTH-1:0]  timeout_ticks;

  // Item latch and state
  logic signed [FW-1:0]          lin_q;
  logic signed [FW-1:0]          ang_q;
  logic signed [VALUE_WIDTH-1:0] target_linear;
  logic signed [VALUE_WIDTH-1:0] target_angular;
  logic signed [VALUE_WIDTH-1:0] current_linear;
  logic signed [VALUE_WIDTH-1:0] current_angular;
  logic [COUNT_WIDTH-1:0]        ticks_since_cmd;

  // Multiply and divide stage
  logic [PW-1:0]     ang_prod;
  logic              ang_neg;
  logic              lin_neg;
  logic              lin_zero;
  logic              lin_sat;
  logic [FW-1:0]     div_rem;
  logic [LW-1:0]     div_quo;

  // Combinational helpers
  logic signed [EW-1:0]   lin_e, ang_e, lim_lin_e, lim_ang_e, step_e;
  logic signed [EW-1:0]   slew_lin, slew_ang;
  logic [VALUE_WIDTH-1:0] mag_lin, mag_ang;
  logic [FW-1:0]          rem_shift;
  logic                   rem_ge;
  logic [PW:0]            ang_sum;
  logic [CPW-1:0]         ang_mag;
  logic [FW-1:0]          throttle_next;
  logic [FW-1:0]          steer_next;

  assign lin_e     = EW'(lin_q);
  assign ang_e     = EW'(ang_q);
  assign lim_lin_e = signed'(EW'(max_linear));
  assign lim_ang_e = signed'(EW'(max_angular));
  assign step_e    = signed'(EW'(accel_step));
  assign slew_lin  = slew(EW'(target_linear), EW'(current_linear), step_e);
  assign slew_ang  = slew(EW'(target_angular), EW'(current_angular), step_e);

  assign mag_lin = current_linear[VALUE_WIDTH-1] ?
                   VALUE_WIDTH'(-current_linear) : VALUE_WIDTH'(current_linear);
  assign mag_ang = current_angular[VALUE_WIDTH-1] ?
                   VALUE_WIDTH'(-current_angular) : VALUE_WIDTH'(current_angular);

  assign rem_shift = {div_rem[FW-2:0], 1'b0};
  assign rem_ge    = rem_shift >= FW'(max_linear);

  assign ang_sum = {1'b0, ang_prod} + ROUND_HALF;
  assign ang_mag = CPW'(ang_sum[PW:vslw_pkg::DEG_SHIFT]);

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_linear    <= vslw_pkg::RST_MAX_LINEAR;
      max_angular   <= vslw_pkg::RST_MAX_ANGULAR;
      accel_step    <= vslw_pkg::RST_ACCEL_STEP;
      timeout_ticks <= vslw_pkg::RST_TIMEOUT_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vslw_pkg::CFG_MAX_LINEAR:    max_linear    <= cfg_data[LW-1:0];
        vslw_pkg::CFG_MAX_ANGULAR:   max_angular   <= cfg_data[LW-1:0];
        vslw_pkg::CFG_ACCEL_STEP:    accel_step    <= cfg_data[LW-1:0];
        vslw_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      lin_q <= linear_cmd;
      ang_q <= angular_cmd;
    end
  end

  // Targets, currents and watchdog counter
  always_ff @(posedge clk) begin
    if (rst) begin
      target_linear   <= '0;
      target_angular  <= '0;
      current_linear  <= '0;
      current_angular <= '0;
      ticks_since_cmd <= '0;
    end else begin
      if (ctl.do_cmd) begin
        target_linear   <= VALUE_WIDTH'(clamp_sym(clamp_sym(lin_e, lim_lin_e), VMAX_E));
        target_angular  <= VALUE_WIDTH'(clamp_sym(clamp_sym(ang_e, lim_ang_e), VMAX_E));
        ticks_since_cmd <= '0;
      end
      if (ctl.do_watch) begin
        // zero targets once the counter passes the timeout
        if (TW'(ticks_since_cmd) > TW'(timeout_ticks)) begin
          target_linear  <= '0;
          target_angular <= '0;
        end
        if (ticks_since_cmd != '1) begin
          ticks_since_cmd <= ticks_since_cmd + 1'b1;
        end
      end
      if (ctl.do_slew) begin
        current_linear  <= VALUE_WIDTH'(slew_lin);
        current_angular <= VALUE_WIDTH'(slew_ang);
      end
    end
  end

  // Angle product, throttle flags and divider setup; then one bit per step
  always_ff @(posedge clk) begin
    if (ctl.do_mul) begin
      ang_prod <= PW'(mag_ang) * PW'(vslw_pkg::DEG_SCALE);
      ang_neg  <= current_angular[VALUE_WIDTH-1];
      lin_neg  <= current_linear[VALUE_WIDTH-1];
      lin_zero <= (mag_lin == '0);
      lin_sat  <= MW'(mag_lin) >= MW'(max_linear);
      div_rem  <= FW'(mag_lin);
      div_quo  <= '0;
    end else if (ctl.div_step) begin
      div_rem <= rem_ge ? rem_shift - FW'(max_linear) : rem_shift;
      div_quo <= {div_quo[LW-2:0], rem_ge};
    end
  end

  // Final sign, saturation and rounding
  always_comb begin
    if (lin_zero) begin
      throttle_next = '0;
    end else if (lin_sat) begin
      throttle_next = lin_neg ? vslw_pkg::SAT_NEG : vslw_pkg::SAT_POS;
    end else begin
      throttle_next = lin_neg ? FW'(0) - {1'b0, div_quo} : {1'b0, div_quo};
    end
    if (ang_neg) begin
      steer_next = (ang_mag > NEG_LIMIT) ? vslw_pkg::SAT_NEG : FW'(0) - ang_mag[FW-1:0];
    end else begin
      steer_next = (ang_mag > POS_LIMIT) ? vslw_pkg::SAT_POS : ang_mag[FW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      throttle    <= signed'(throttle_next);
      steer_angle <= signed'(steer_next);
    end
  end

endmodule

`default_nettype wire

/* src/velocity_slew_limiter_watchdog_top.sv */
// -----------------------------------------------------------------------------
// velocity_slew_limiter_watchdog_top
// Velocity slew limiter with command watchdog: throttle and steering out.
// -----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  in        in_valid / in_ready   command, linear_cmd, angular_cmd
//  out       out_valid / out_ready throttle, steer_angle
//  cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
//  A velocity command passes the command state before the input opens again.
//  A tick passes the watchdog, slew and angle multiply states, then the 15-step
//  restoring divider for throttle. A finished tick waits in the last state
//  only while the output register still holds an untaken result. Reset clears
//  targets, velocities, the counter and the registers to their defaults;
//  cfg_ready is always high.
// -----------------------------------------------------------------------------
`default_nettype none

module velocity_slew_limiter_watchdog_top #(
  parameter int VALUE_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output      logic                                    in_ready,
  input  wire logic                                    command,
  input  wire logic signed [vslw_pkg::FIELD_WIDTH-1:0] linear_cmd,
  input  wire logic signed [vslw_pkg::FIELD_WIDTH-1:0] angular_cmd,
  output      logic                                    out_valid,
  input  wire logic                                    out_ready,
  output      logic signed [vslw_pkg::FIELD_WIDTH-1:0] throttle,
  output      logic signed [vslw_pkg::FIELD_WIDTH-1:0] steer_angle,
  input  wire logic                                    cfg_valid,
  output      logic                                    cfg_ready,
  input  wire logic [vslw_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [vslw_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  vslw_pkg::vslw_cmd_t ctl;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  vslw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  vslw_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .linear_cmd  (linear_cmd),
    .angular_cmd (angular_cmd),
    .throttle    (throttle),
    .steer_angle (steer_angle)
  );

endmodule

`default_nettype wire

/* src/vslw_checker.sv */
// -----------------------------------------------------------------------------
// vslw_checker
// Port-level checks on sequencing and output hold, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "velocity_slew_limiter_watchdog_top_defines.svh"

module vslw_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                command,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [vslw_pkg::FIELD_WIDTH-1:0]    throttle,
  input wire logic [vslw_pkg::FIELD_WIDTH-1:0]    steer_angle
);

  logic in_xfer;
  logic tick_xfer;
  assign in_xfer   = in_valid && in_ready;
  assign tick_xfer = in_xfer && (command == vslw_pkg::CMD_TICK);

  // Reset leaves an empty output and an open input
  `VSLW_ASSERT_NEXT(a_reset_state, clk, 1'b0, rst, !out_valid && in_ready, "reset state wrong")

  // Each item is worked on alone
  `VSLW_ASSERT_NEXT(a_one_item, clk, rst, in_xfer, !in_ready, "input open during work")

  // A tick keeps the input closed through the watchdog and slew states
  `VSLW_ASSERT_NEXT(a_tick_busy, clk, rst, tick_xfer, !in_ready ##1 !in_ready,
                    "tick finished too early")

  // A stalled result holds
  `VSLW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(throttle) && $stable(steer_angle),
                    "stalled result changed")

endmodule

bind velocity_slew_limiter_watchdog_top vslw_checker u_vslw_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .command     (command),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .throttle    (throttle),
  .steer_angle (steer_angle)
);

`default_nettype wire
